// ===== rtl/core/rbcb_pkg.sv =====
// shared types, register codes and colour packing for the clipped bitmap blitter
// no dependencies; imported by rgb_bitmap_clip_blitter and its testbench
package rbcb_pkg;

  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 11;
  localparam int unsigned CountWidth   = 10;
  localparam int unsigned CoordWidth   = 11;
  localparam int unsigned ScreenWidth  = 12;
  localparam int unsigned OffsetWidth  = 17;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgImageX      = 3'd0,
    CfgImageY      = 3'd1,
    CfgImageWidth  = 3'd2,
    CfgImageHeight = 3'd3,
    CfgClipX       = 3'd4,
    CfgClipY       = 3'd5,
    CfgClipWidth   = 3'd6,
    CfgClipHeight  = 3'd7
  } cfg_idx_e;

  // first stage word: colour plus screen position
  typedef struct packed {
    logic [23:0]                   rgb;
    logic signed [ScreenWidth-1:0] sx;
    logic signed [ScreenWidth-1:0] sy;
  } stage_t;

  function automatic logic [15:0] to_rgb565(input logic [23:0] c);
    to_rgb565 = {c[23:19], c[15:10], c[7:3]};
  endfunction

endpackage

// ===== rtl/core/rgb_bitmap_clip_blitter.sv =====
// clipped bitmap blitter: rgb888 pixel stream in, rgb565 framebuffer writes out
// depends on rbcb_pkg (register codes, stage word, colour packing)
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+---------------------------------
//  in       | input     | in_valid_i / in_stall_o    | pixel_rgb_i
//  out      | output    | out_valid_o / out_stall_i  | pixel_offset_o, rgb565_o,
//           |           |                            | off_screen_o
//  cfg      | input     | cfg_we_i (no wait)         | cfg_idx_i, cfg_data_i
//
// one word per clock while out_stall_i is low; a pixel's result is registered in stage 1, then in the output register
// stage 1 holds the screen position, stage 2 does clip test and offset multiply
// reset clears registers, counters and valid flags; payload registers are not reset
// an out stall holds the output register; stage 1 keeps filling until it is also full
module rgb_bitmap_clip_blitter #(
  parameter int DISPLAY_WIDTH  = 480,
  parameter int DISPLAY_HEIGHT = 272,
  parameter int ROTATION       = 0
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [rbcb_pkg::CfgIdxWidth-1:0]     cfg_idx_i,
  input  logic [rbcb_pkg::CfgDataWidth-1:0]    cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [23:0]                          pixel_rgb_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [rbcb_pkg::OffsetWidth-1:0]     pixel_offset_o,
  output logic [15:0]                          rgb565_o,
  output logic                                 off_screen_o
);
  import rbcb_pkg::*;

  // only the low two bits of the rotation setting matter
  localparam logic [1:0] Rot = 2'(ROTATION % 4);
  // logical screen size after the quarter turn
  localparam int LogW = (Rot == 2'd0 || Rot == 2'd2) ? DISPLAY_WIDTH : DISPLAY_HEIGHT;
  localparam int LogH = (Rot == 2'd0 || Rot == 2'd2) ? DISPLAY_HEIGHT : DISPLAY_WIDTH;
  localparam logic signed [13:0] LogWS = 14'(LogW);
  localparam logic signed [13:0] LogHS = 14'(LogH);
  localparam logic [OffsetWidth-1:0] W17 = OffsetWidth'(DISPLAY_WIDTH);
  localparam logic [OffsetWidth-1:0] H17 = OffsetWidth'(DISPLAY_HEIGHT);
  localparam logic [OffsetWidth-1:0] One17 = OffsetWidth'(1);

  // configuration registers
  logic signed [CoordWidth-1:0] image_x_q, image_y_q, clip_x_q, clip_y_q;
  logic [CountWidth-1:0]        image_w_q, image_h_q, clip_w_q, clip_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_x_q <= '0;
      image_y_q <= '0;
      image_w_q <= '0;
      image_h_q <= '0;
      clip_x_q  <= '0;
      clip_y_q  <= '0;
      clip_w_q  <= '0;
      clip_h_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgImageX:      image_x_q <= cfg_data_i;
        CfgImageY:      image_y_q <= cfg_data_i;
        CfgImageWidth:  image_w_q <= cfg_data_i[CountWidth-1:0];
        CfgImageHeight: image_h_q <= cfg_data_i[CountWidth-1:0];
        CfgClipX:       clip_x_q  <= cfg_data_i;
        CfgClipY:       clip_y_q  <= cfg_data_i;
        CfgClipWidth:   clip_w_q  <= cfg_data_i[CountWidth-1:0];
        CfgClipHeight:  clip_h_q  <= cfg_data_i[CountWidth-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control: output register moves when empty or taken
  logic   out_valid_q, s1_valid_q;
  logic   advance, s1_load, in_accept;
  stage_t s1_q, s1_d;

  assign advance    = !out_valid_q || !out_stall_i;
  assign s1_load    = !s1_valid_q || advance;
  assign in_stall_o = !s1_load;
  assign in_accept  = in_valid_i && s1_load;

  // empty image: word is swallowed, counters hold
  logic nonempty;
  assign nonempty = (image_w_q != '0) && (image_h_q != '0);

  // column / row counters
  logic [CountWidth-1:0] col_q, col_d, row_q, row_d;
  logic [CountWidth:0]   col_inc, row_inc;

  assign col_inc = {1'b0, col_q} + 1'b1;
  assign row_inc = {1'b0, row_q} + 1'b1;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_accept && nonempty) begin
      // a counter past a shrunken size still wraps here
      if (col_inc >= {1'b0, image_w_q}) begin
        col_d = '0;
        if (row_inc >= {1'b0, image_h_q}) begin
          row_d = '0;
        end else begin
          row_d = row_inc[CountWidth-1:0];
        end
      end else begin
        col_d = col_inc[CountWidth-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // stage 1: screen position of the pixel
  always_comb begin
    s1_d.rgb = pixel_rgb_i;
    s1_d.sx  = ScreenWidth'(image_x_q) + $signed({2'b00, col_q});
    s1_d.sy  = ScreenWidth'(image_y_q) + $signed({2'b00, row_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_load) begin
      s1_valid_q <= in_accept && nonempty;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q <= s1_d;
    end
  end

  // stage 2: clip test, display test, rotated offset
  logic signed [ScreenWidth-1:0] clip_x_end, clip_y_end;
  logic signed [13:0]            sx_ext, sy_ext;
  logic                          in_clip, off;
  logic [OffsetWidth-1:0]        ux, uy, offset;

  assign clip_x_end = ScreenWidth'(clip_x_q) + $signed({2'b00, clip_w_q});
  assign clip_y_end = ScreenWidth'(clip_y_q) + $signed({2'b00, clip_h_q});

  assign in_clip = (s1_q.sx >= ScreenWidth'(clip_x_q)) && (s1_q.sx < clip_x_end) &&
                   (s1_q.sy >= ScreenWidth'(clip_y_q)) && (s1_q.sy < clip_y_end);

  assign sx_ext = 14'(s1_q.sx);
  assign sy_ext = 14'(s1_q.sy);
  assign off = s1_q.sx[ScreenWidth-1] || s1_q.sy[ScreenWidth-1] ||
               (sx_ext >= LogWS) || (sy_ext >= LogHS);

  // modulo 2^17 arithmetic matches the masked offset
  assign ux = OffsetWidth'(s1_q.sx[ScreenWidth-2:0]);
  assign uy = OffsetWidth'(s1_q.sy[ScreenWidth-2:0]);

  always_comb begin
    offset = '0;
    if (!off) begin
      unique case (Rot)
        2'd0:    offset = uy * W17 + ux;
        2'd1:    offset = ux * W17 + (W17 - One17 - uy);
        2'd2:    offset = (H17 - One17 - uy) * W17 + (W17 - One17 - ux);
        default: offset = (H17 - One17 - ux) * W17 + uy;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q && in_clip;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q && in_clip) begin
      pixel_offset_o <= offset;
      rgb565_o       <= to_rgb565(s1_q.rgb);
      off_screen_o   <= off;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== sim/rgb_bitmap_clip_blitter_tb.sv =====
// testbench for rgb_bitmap_clip_blitter: drives rgb888 pixel streams through
// several image and clip windows and checks each framebuffer write against a local predictor
// depends on rbcb_pkg and rgb_bitmap_clip_blitter
`timescale 1ns / 1ps

module rgb_bitmap_clip_blitter_tb;
  import rbcb_pkg::*;

  localparam int DispW = 480;
  localparam int DispH = 272;
  localparam int Rot   = 0;

  // quarter-turn settings of the display
  localparam int RotNone         = 0;
  localparam int RotQuarter      = 1;
  localparam int RotHalf         = 2;
  localparam int RotThreeQuarter = 3;

  localparam int CycleLimit = 400000;

  // one framebuffer write as it leaves the block
  typedef struct packed {
    logic [OffsetWidth-1:0] offset;
    logic [15:0]            colour;
    logic                   off_screen;
  } fb_write_t;

  logic                    clk_i          = 1'b0;
  logic                    rst_ni         = 1'b0;
  logic                    cfg_we_i       = 1'b0;
  logic [CfgIdxWidth-1:0]  cfg_idx_i      = '0;
  logic [CfgDataWidth-1:0] cfg_data_i     = '0;
  logic                    in_valid_i     = 1'b0;
  logic                    in_stall_o;
  logic [23:0]             pixel_rgb_i    = '0;
  logic                    out_valid_o;
  logic                    out_stall_i    = 1'b0;
  logic [OffsetWidth-1:0]  pixel_offset_o;
  logic [15:0]             rgb565_o;
  logic                    off_screen_o;

  // predictor copy of the register file and the image position counters
  logic [CfgDataWidth-1:0] reg_shadow [8] = '{default: '0};
  int                      col_pos = 0;
  int                      row_pos = 0;

  fb_write_t fb_writes_due[$];

  int bad_words     = 0;
  int cycle_count   = 0;
  bit in_idle_on    = 1'b1;
  bit out_idle_on   = 1'b1;
  int hold_request  = 0;
  int hold_left     = 0;

  rgb_bitmap_clip_blitter #(
    .DISPLAY_WIDTH (DispW),
    .DISPLAY_HEIGHT(DispH),
    .ROTATION      (Rot)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pixel_rgb_i   (pixel_rgb_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_offset_o(pixel_offset_o),
    .rgb565_o      (rgb565_o),
    .off_screen_o  (off_screen_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // watchdog on the whole run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("[rgb_bitmap_clip_blitter] ERROR");
      $finish;
    end
  end

  // works out the write (if any) caused by one accepted pixel and steps the counters
  task automatic predict_fb_write(input logic [23:0] rgb);
    int        iw, ih, sx, sy, cx, cy, cw, ch, lw, lh, ofs;
    logic      hit, off;
    fb_write_t w;
    iw = reg_shadow[CfgImageWidth][9:0];
    ih = reg_shadow[CfgImageHeight][9:0];
    // an empty image swallows the pixel and leaves the counters alone
    if (iw == 0 || ih == 0) return;
    sx  = $signed(reg_shadow[CfgImageX]) + col_pos;
    sy  = $signed(reg_shadow[CfgImageY]) + row_pos;
    cx  = $signed(reg_shadow[CfgClipX]);
    cy  = $signed(reg_shadow[CfgClipY]);
    cw  = reg_shadow[CfgClipWidth][9:0];
    ch  = reg_shadow[CfgClipHeight][9:0];
    hit = (sx >= cx) && (sx < cx + cw) && (sy >= cy) && (sy < cy + ch);
    if (hit) begin
      if (Rot % 4 == RotNone || Rot % 4 == RotHalf) begin
        lw = DispW;
        lh = DispH;
      end else begin
        lw = DispH;
        lh = DispW;
      end
      off = (sx < 0) || (sy < 0) || (sx >= lw) || (sy >= lh);
      ofs = 0;
      if (!off) begin
        case (Rot % 4)
          RotNone:    ofs = sy * DispW + sx;
          RotQuarter: ofs = sx * DispW + (DispW - 1 - sy);
          RotHalf:    ofs = (DispH - 1 - sy) * DispW + (DispW - 1 - sx);
          default:    ofs = (DispH - 1 - sx) * DispW + sy;
        endcase
      end
      w.offset     = ofs[OffsetWidth-1:0];
      w.colour     = {rgb[23:19], rgb[15:10], rgb[7:3]};
      w.off_screen = off;
      fb_writes_due.push_back(w);
    end
    // a counter left at or past a shrunken size is used once, then wraps
    if (col_pos + 1 >= iw) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= ih) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  // writes all eight registers in index order, one per clock
  task automatic program_window(input int ix, input int iy, input int iw, input int ih,
                                input int cx, input int cy, input int cw, input int ch);
    logic [CfgDataWidth-1:0] vals [8];
    cfg_idx_e                idx;
    vals = '{ix[10:0], iy[10:0], iw[10:0], ih[10:0], cx[10:0], cy[10:0], cw[10:0], ch[10:0]};
    for (int i = 0; i < 8; i++) begin
      idx        = cfg_idx_e'(i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx;
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      // size registers keep only their low ten bits
      case (idx)
        CfgImageWidth, CfgImageHeight, CfgClipWidth, CfgClipHeight: begin
          reg_shadow[idx] = {1'b0, vals[i][9:0]};
        end
        default: begin
          reg_shadow[idx] = vals[i];
        end
      endcase
    end
    cfg_we_i <= 1'b0;
  endtask

  // offers one pixel word, with an occasional gap first, and waits for it to be taken
  task automatic send_pixel(input logic [23:0] rgb);
    if (in_idle_on && $urandom_range(0, 99) < 25) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < 25);
    end
    in_valid_i  <= 1'b1;
    pixel_rgb_i <= rgb;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_fb_write(rgb);
  endtask

  // stop offering, let every expected write come out, then cover the pipeline depth
  // for pixels that made no write
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (fb_writes_due.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // receiver: random stalls, or a long counted hold when a test asks for one
  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= out_idle_on && ($urandom_range(0, 99) < 25);
    end
  end

  // every accepted output word is matched against the oldest expected write
  always @(posedge clk_i) begin
    fb_write_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{pixel_offset_o, rgb565_o, off_screen_o};
      if (fb_writes_due.size() == 0) begin
        bad_words++;
        if (bad_words <= 10)
          $display("unexpected word: offset %0d rgb565 %h off_screen %0b",
                   got.offset, got.colour, got.off_screen);
      end else begin
        want = fb_writes_due.pop_front();
        if (got.offset !== want.offset || got.colour !== want.colour ||
            got.off_screen !== want.off_screen) begin
          bad_words++;
          if (bad_words <= 10)
            $display({"mismatch: offset exp %0d got %0d, rgb565 exp %h got %h, ",
                      "off_screen exp %0b got %0b"},
                     want.offset, got.offset, want.colour, got.colour,
                     want.off_screen, got.off_screen);
        end
      end
    end
  end

  // registers are all zero after reset, so the image is empty and nothing comes out
  task automatic test_empty_after_reset();
    repeat (3) send_pixel($urandom());
    wait_idle();
  endtask

  // one short row at the origin, colours at the channel extremes
  task automatic test_colour_extremes();
    program_window(0, 0, 6, 1, 0, 0, 1023, 1023);
    send_pixel(24'h000000);
    send_pixel(24'hffffff);
    send_pixel(24'hf80000);
    send_pixel(24'h00fc00);
    send_pixel(24'h0000f8);
    send_pixel(24'h070307);
    wait_idle();
  endtask

  // display corner straddle, most negative and most positive image origins
  task automatic test_off_display();
    program_window(DispW - 1, DispH - 1, 2, 2, 400, 200, 1023, 1023);
    repeat (4) send_pixel($urandom());
    wait_idle();
    program_window(-1024, -1024, 1, 1, -1024, -1024, 1023, 1023);
    send_pixel($urandom());
    wait_idle();
    program_window(1023, 1023, 1, 1, 1000, 1000, 1023, 1023);
    send_pixel($urandom());
    wait_idle();
  endtask

  // counters left beyond a shrunken width, then a zero-width clip
  task automatic test_shrink_and_zero_clip();
    program_window(0, 0, 1023, 1023, 0, 0, 1023, 1023);
    repeat (5) send_pixel($urandom());
    wait_idle();
    program_window(0, 0, 3, 1023, 0, 0, 1023, 1023);
    repeat (2) send_pixel($urandom());
    wait_idle();
    program_window(0, 0, 4, 4, 0, 0, 0, 1023);
    repeat (2) send_pixel($urandom());
    wait_idle();
  endtask

  // receiver holds off for a long stretch while pixels keep coming, so the
  // pipeline fills and the input stalls
  task automatic test_backpressure();
    program_window(20, 20, 16, 8, 0, 0, 1023, 1023);
    in_idle_on   = 1'b0;
    out_idle_on  = 1'b0;
    hold_request = 150;
    repeat (40) send_pixel($urandom());
    wait_idle();
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
  endtask

  // random windows, mostly with the clip around the image, some pure noise
  task automatic test_random_frames(input int target);
    int sent, phase, iw, ih, ix, iy, cx, cy, cw, ch, n;
    sent  = 0;
    phase = 0;
    while (sent < target) begin
      iw = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 1023) : $urandom_range(1, 24);
      ih = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 1023) : $urandom_range(1, 12);
      if ($urandom_range(0, 19) == 0) begin
        if ($urandom_range(0, 1) != 0) iw = 0;
        else ih = 0;
      end
      if ($urandom_range(0, 99) < 15) begin
        ix = $urandom_range(0, 2047);
        iy = $urandom_range(0, 2047);
      end else begin
        ix = int'($urandom_range(0, 540)) - 40;
        iy = int'($urandom_range(0, 330)) - 40;
      end
      if ($urandom_range(0, 99) < 15) begin
        cx = $urandom_range(0, 2047);
        cy = $urandom_range(0, 2047);
        cw = $urandom_range(0, 1023);
        ch = $urandom_range(0, 1023);
      end else begin
        cx = ix + int'($urandom_range(0, 16)) - 8;
        cy = iy + int'($urandom_range(0, 16)) - 8;
        cw = $urandom_range(0, iw + 8);
        ch = $urandom_range(0, ih + 8);
      end
      // the unused top data bit of a size register should be dropped
      iw = iw | ($urandom_range(0, 1) << 10);
      ih = ih | ($urandom_range(0, 1) << 10);
      cw = cw | ($urandom_range(0, 1) << 10);
      ch = ch | ($urandom_range(0, 1) << 10);
      // a run of phases with both sides running flat out
      in_idle_on  = !(phase >= 4 && phase < 8);
      out_idle_on = in_idle_on;
      program_window(ix, iy, iw, ih, cx, cy, cw, ch);
      n = $urandom_range(10, 60);
      repeat (n) send_pixel($urandom());
      if (iw[9:0] != 0 && ih[9:0] != 0) sent += n;
      wait_idle();
      phase++;
    end
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_after_reset();
    test_colour_extremes();
    test_off_display();
    test_shrink_and_zero_clip();
    test_backpressure();
    test_random_frames(740);
    if (bad_words == 0 && fb_writes_due.size() == 0) begin
      $display("[rgb_bitmap_clip_blitter] OK");
    end else begin
      $display("[rgb_bitmap_clip_blitter] ERROR");
    end
    $finish;
  end

endmodule
